>>> rtl/lz77wd_pkg.sv
package lz77wd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int AW = $clog2(WINDOW_DEPTH);
  // copy length is 2..17
  localparam int LW = 5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } out_t;

  typedef struct packed {
    logic clr_en;
    logic take;
    logic rd_en;
    logic consume;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic have;
    logic rd_left_zero;
    logic wr_last;
    logic copy_go;
  } sts_t;

endpackage

>>> rtl/lz77_window_decompressor.sv
// Timing: a literal or end beat shows on res in the cycle after its input beat is taken;
// a token's first copied byte is read into rdata, then moved to res, after its high byte.
// Throughput: one input beat per cycle, while the output is not stalled, for flag, literal
// and token-low bytes; a token's high byte holds the input while its copy runs, one copied
// byte per cycle through the single-port window read, less any output stall.
// Reset: synchronous; a pass then zeroes all 4096 window bytes, no input taken until done.
module lz77_window_decompressor (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lz77wd_pkg::in_t   item,
  output logic              res_valid,
  input  logic              res_stall,
  output lz77wd_pkg::out_t  res
);
  import lz77wd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ready;

  assign item_stall = !ready;

  lz77wd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .sts        (sts),
    .cmd        (cmd),
    .ready      (ready)
  );

  lz77wd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .res_stall (res_stall),
    .sts       (sts),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

>>> rtl/lz77wd_ctrl.sv
module lz77wd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  lz77wd_pkg::sts_t  sts,
  output lz77wd_pkg::cmd_t  cmd,
  output logic              ready
);
  import lz77wd_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_COPY  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    ready      = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ready    = sts.out_free;
        cmd.take = item_valid && sts.out_free;
        if (cmd.take && sts.copy_go) state_next = S_COPY;
      end
      S_COPY: begin
        // one read in flight; next read goes out as the held byte drains
        cmd.consume = sts.have && sts.out_free;
        cmd.rd_en   = !sts.rd_left_zero && (!sts.have || cmd.consume);
        if (cmd.consume && sts.wr_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/lz77wd_dpath.sv
module lz77wd_dpath (
  input  logic              clk,
  input  logic              rst,
  input  lz77wd_pkg::in_t   item,
  input  lz77wd_pkg::cmd_t  cmd,
  input  logic              res_stall,
  output lz77wd_pkg::sts_t  sts,
  output logic              res_valid,
  output lz77wd_pkg::out_t  res
);
  import lz77wd_pkg::*;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_DATA = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  logic [7:0]    mem [WINDOW_DEPTH];
  logic [7:0]    rdata;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] wp;
  logic [AW-1:0] src;
  logic [LW-1:0] rd_left;
  logic [LW-1:0] wr_left;
  logic          have;
  logic [7:0]    flag_bits;
  logic [7:0]    flag_mask;
  phase_t        phase;
  logic [7:0]    token_low;
  logic          finished;

  logic          live;
  logic          flag_hit;
  logic [AW-1:0] tok_src;
  logic [LW-1:0] tok_len;
  logic          lit_wr;
  logic          end_hit;
  logic [8:0]    mask_sh;
  logic [7:0]    nf_mask;
  phase_t        nf_phase;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  always_comb begin
    live     = !item.chunk_start && !finished;
    flag_hit = |(flag_bits & flag_mask);
    tok_src  = {item.in_byte, token_low[7:4]};
    tok_len  = {1'b0, token_low[3:0]} + LW'(2);
    lit_wr   = cmd.take && live && phase == PH_DATA && !flag_hit;
    end_hit  = cmd.take && live && phase == PH_HIGH && tok_src == '0;
    mask_sh  = {flag_mask, 1'b0};
    nf_mask  = mask_sh[8] ? 8'd1 : mask_sh[7:0];
    nf_phase = mask_sh[8] ? PH_FLAG : PH_DATA;

    we    = cmd.clr_en || lit_wr || cmd.consume;
    waddr = cmd.clr_en ? clr_cnt : wp;
    wdata = cmd.clr_en ? 8'd0 : (cmd.consume ? rdata : item.in_byte);

    sts.clr_last     = &clr_cnt;
    sts.out_free     = !res_valid || !res_stall;
    sts.have         = have;
    sts.rd_left_zero = rd_left == '0;
    sts.wr_last      = wr_left == LW'(1);
    sts.copy_go      = live && phase == PH_HIGH && tok_src != '0;
  end

  // window: one write, one registered read; a read of the byte written in the
  // same cycle takes the new value so overlapping copies see fresh data
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= (we && waddr == src) ? wdata : mem[src];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      wp        <= AW'(1);
      src       <= '0;
      rd_left   <= '0;
      wr_left   <= '0;
      have      <= 1'b0;
      flag_bits <= '0;
      flag_mask <= 8'd1;
      phase     <= PH_FLAG;
      token_low <= '0;
      finished  <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.take) begin
        if (item.chunk_start) begin
          flag_bits <= item.in_byte;
          flag_mask <= 8'd1;
          phase     <= PH_DATA;
          wp        <= AW'(1);
          finished  <= 1'b0;
        end else if (!finished) begin
          case (phase)
            PH_DATA: begin
              if (!flag_hit) begin
                wp        <= wp + AW'(1);
                flag_mask <= nf_mask;
                phase     <= nf_phase;
              end else begin
                token_low <= item.in_byte;
                phase     <= PH_HIGH;
              end
            end
            PH_HIGH: begin
              if (tok_src == '0) begin
                finished <= 1'b1;
                phase    <= PH_FLAG;
              end else begin
                src       <= tok_src;
                rd_left   <= tok_len;
                wr_left   <= tok_len;
                flag_mask <= nf_mask;
                phase     <= nf_phase;
              end
            end
            default: begin
              flag_bits <= item.in_byte;
              flag_mask <= 8'd1;
              phase     <= PH_DATA;
            end
          endcase
        end
      end
      if (cmd.rd_en) begin
        src     <= src + AW'(1);
        rd_left <= rd_left - LW'(1);
      end
      if (cmd.consume) begin
        wp      <= wp + AW'(1);
        wr_left <= wr_left - LW'(1);
      end
      if (cmd.rd_en) begin
        have <= 1'b1;
      end else if (cmd.consume) begin
        have <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (lit_wr || end_hit || cmd.consume) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lit_wr) begin
      res <= '{out_byte: item.in_byte, run_last: 1'b1, stream_end: 1'b0};
    end else if (end_hit) begin
      res <= '{out_byte: 8'd0, run_last: 1'b1, stream_end: 1'b1};
    end else if (cmd.consume) begin
      res <= '{out_byte: rdata, run_last: sts.wr_last, stream_end: 1'b0};
    end
  end

endmodule
